### hw/rtl/bsa_pkg.sv
package bsa_pkg;

    // Geometry of the free bitmap
    localparam int SLOTS      = 128;
    localparam int WORD_BITS  = 32;
    localparam int WORDS      = SLOTS / WORD_BITS;
    localparam int MAP_SLOTS  = WORDS * WORD_BITS;
    localparam int FREE_LIMIT = (SLOTS < MAP_SLOTS) ? SLOTS : MAP_SLOTS;

    localparam int WORD_IDX_W  = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int BIT_W       = $clog2(WORD_BITS);
    localparam int SLOT_CALC_W = $clog2(MAP_SLOTS);

    // Fixed transaction field widths
    localparam int OPCODE_W = 1;
    localparam int REQ_W    = 8;
    localparam int SLOT_W   = 7;
    localparam int STATUS_W = 2;

    localparam logic [WORD_IDX_W-1:0] WORD_LAST = WORD_IDX_W'(WORDS - 1);

    // Command queue between front and back
    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
    localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

    localparam logic [OPCODE_W-1:0] OP_ALLOC = 1'b0;
    localparam logic [OPCODE_W-1:0] OP_FREE  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_NONE  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        CMD_ALLOC,
        CMD_FREE,
        CMD_REJECT
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind               kind;
        logic [WORD_IDX_W-1:0]   word;
        logic [BIT_W-1:0]        bit_idx;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_cmd_head;

    typedef enum logic {
        BK_IDLE,
        BK_SCAN
    } t_back_state;

endpackage

### hw/rtl/bsa_front.sv
module bsa_front (
    input  logic                         push,
    output logic                         full,
    input  logic [bsa_pkg::OPCODE_W-1:0] i_opcode,
    input  logic [bsa_pkg::REQ_W-1:0]    i_slot_to_free,
    input  logic                         i_q_full,
    output logic                         o_q_push,
    output bsa_pkg::t_cmd                o_q_cmd
);
    import bsa_pkg::*;

    logic [WORD_IDX_W-1:0] word;
    logic                  in_range;

    // Word index by compare against each word base; bit is the remainder
    always_comb begin
        word = '0;
        for (int w = 0; w < WORDS; w++) begin
            if (16'(i_slot_to_free) >= 16'(w * WORD_BITS)) begin
                word = WORD_IDX_W'(w);
            end
        end
    end

    assign in_range = 16'(i_slot_to_free) < 16'(FREE_LIMIT);

    always_comb begin
        o_q_cmd.word    = word;
        o_q_cmd.bit_idx = BIT_W'(16'(i_slot_to_free) - 16'(word) * 16'(WORD_BITS));
        if (i_opcode == OP_ALLOC) begin
            o_q_cmd.kind = CMD_ALLOC;
        end else if (in_range) begin
            o_q_cmd.kind = CMD_FREE;
        end else begin
            o_q_cmd.kind = CMD_REJECT;
        end
    end

    assign full     = i_q_full;
    assign o_q_push = push && !i_q_full;

endmodule

### hw/rtl/bsa_cmd_queue.sv
module bsa_cmd_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  bsa_pkg::t_cmd      i_cmd,
    output logic               o_full,
    output bsa_pkg::t_cmd_head o_head,
    input  logic               i_pop
);
    import bsa_pkg::*;

    t_cmd                  r_mem [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0] r_wptr;
    logic [CMDQ_PTR_W-1:0] r_rptr;
    logic [CMDQ_CNT_W-1:0] r_count;
    logic                  do_push;
    logic                  do_pop;

    function automatic logic [CMDQ_PTR_W-1:0] ptr_inc(input logic [CMDQ_PTR_W-1:0] p);
        ptr_inc = (p == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_full     = (r_count == CMDQ_CNT_W'(CMDQ_DEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.cmd   = r_mem[r_rptr];
    assign do_push    = i_push && !o_full;
    assign do_pop     = i_pop && o_head.valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= ptr_inc(r_wptr);
            end
            if (do_pop) begin
                r_rptr <= ptr_inc(r_rptr);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

### hw/rtl/bsa_back.sv
module bsa_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  bsa_pkg::t_cmd_head           i_head,
    output logic                         o_cmd_pop,
    output logic                         empty,
    input  logic                         pop,
    output logic [bsa_pkg::SLOT_W-1:0]   o_slot,
    output logic [bsa_pkg::STATUS_W-1:0] o_status
);
    import bsa_pkg::*;

    t_back_state            r_state;
    t_back_state            n_state;
    logic [WORD_BITS-1:0]   r_free_map [WORDS];
    logic [WORD_IDX_W-1:0]  r_cursor;
    logic [WORD_IDX_W-1:0]  n_cursor;
    logic [WORD_IDX_W-1:0]  r_scan_cnt;
    logic [WORD_IDX_W-1:0]  n_scan_cnt;
    logic                   r_out_valid;
    logic [SLOT_W-1:0]      r_out_slot;
    t_status                r_out_status;

    logic [WORD_BITS-1:0]   cur_word;
    logic                   hit;
    logic [BIT_W-1:0]       top;
    logic [WORD_IDX_W-1:0]  cursor_next;
    logic [SLOT_CALC_W-1:0] slot_calc;
    logic                   out_avail;
    logic                   set_en;
    logic                   clr_en;
    logic                   res_load;
    logic [SLOT_W-1:0]      res_slot;
    t_status                res_status;

    // Highest set bit; zero word gives zero
    function automatic logic [BIT_W-1:0] top_bit(input logic [WORD_BITS-1:0] w);
        logic [BIT_W-1:0] b;
        b = '0;
        for (int i = 0; i < WORD_BITS; i++) begin
            if (w[i]) begin
                b = BIT_W'(i);
            end
        end
        return b;
    endfunction

    assign cur_word    = r_free_map[r_cursor];
    assign hit         = |cur_word;
    assign top         = top_bit(cur_word);
    assign cursor_next = (r_cursor == WORD_LAST) ? '0 : r_cursor + 1'b1;
    assign slot_calc   = SLOT_CALC_W'(r_cursor) * SLOT_CALC_W'(WORD_BITS)
                       + SLOT_CALC_W'(top);
    assign out_avail   = !r_out_valid || pop;

    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: begin
                if (i_head.valid && i_head.cmd.kind == CMD_ALLOC) begin
                    n_state = BK_SCAN;
                end
            end
            BK_SCAN: begin
                if (out_avail && (hit || r_scan_cnt == WORD_LAST)) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_comb begin
        o_cmd_pop  = 1'b0;
        set_en     = 1'b0;
        clr_en     = 1'b0;
        res_load   = 1'b0;
        res_slot   = '0;
        res_status = ST_OK;
        n_cursor   = r_cursor;
        n_scan_cnt = r_scan_cnt;
        case (r_state)
            BK_IDLE: begin
                if (i_head.valid) begin
                    case (i_head.cmd.kind)
                        CMD_ALLOC: begin
                            o_cmd_pop  = 1'b1;
                            n_scan_cnt = '0;
                        end
                        CMD_FREE: begin
                            if (out_avail) begin
                                o_cmd_pop = 1'b1;
                                set_en    = 1'b1;
                                res_load  = 1'b1;
                                n_cursor  = i_head.cmd.word;
                            end
                        end
                        CMD_REJECT: begin
                            if (out_avail) begin
                                o_cmd_pop  = 1'b1;
                                res_load   = 1'b1;
                                res_status = ST_RANGE;
                            end
                        end
                        default: o_cmd_pop = 1'b0;
                    endcase
                end
            end
            BK_SCAN: begin
                if (out_avail) begin
                    if (hit) begin
                        clr_en   = 1'b1;
                        res_load = 1'b1;
                        res_slot = SLOT_W'(slot_calc);
                    end else begin
                        n_cursor   = cursor_next;
                        n_scan_cnt = r_scan_cnt + 1'b1;
                        if (r_scan_cnt == WORD_LAST) begin
                            res_load   = 1'b1;
                            res_status = ST_NONE;
                        end
                    end
                end
            end
            default: o_cmd_pop = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_cursor    <= '0;
            r_scan_cnt  <= '0;
            r_out_valid <= 1'b0;
            for (int w = 0; w < WORDS; w++) begin
                r_free_map[w] <= '1;
            end
        end else begin
            r_state    <= n_state;
            r_cursor   <= n_cursor;
            r_scan_cnt <= n_scan_cnt;
            if (res_load) begin
                r_out_valid <= 1'b1;
            end else if (pop) begin
                r_out_valid <= 1'b0;
            end
            for (int w = 0; w < WORDS; w++) begin
                if (set_en && i_head.cmd.word == WORD_IDX_W'(w)) begin
                    r_free_map[w][i_head.cmd.bit_idx] <= 1'b1;
                end
                if (clr_en && r_cursor == WORD_IDX_W'(w)) begin
                    r_free_map[w][top] <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_load) begin
            r_out_slot   <= res_slot;
            r_out_status <= res_status;
        end
    end

    assign empty    = !r_out_valid;
    assign o_slot   = r_out_slot;
    assign o_status = r_out_status;

endmodule

### hw/rtl/bitmap_slot_allocator.sv
// Flow: a free or rejected free goes from the command queue to the result register; an
//   allocate goes to BK_SCAN, which scans from the cursor past all-zero words.
// Throughput: one free per cycle while the result register is empty or being popped;
//   an allocate holds the back end for its one-word-per-cycle bitmap scan.
// Reset (i_rst_n, synchronous, active low): every slot free, cursor at word 0,
//   command queue and result register empty.
module bitmap_slot_allocator (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // request side
    input  logic                         push,
    output logic                         full,
    input  logic [bsa_pkg::OPCODE_W-1:0] i_opcode,
    input  logic [bsa_pkg::REQ_W-1:0]    i_slot_to_free,
    // result side
    output logic                         empty,
    input  logic                         pop,
    output logic [bsa_pkg::SLOT_W-1:0]   o_slot,
    output logic [bsa_pkg::STATUS_W-1:0] o_status
);
    import bsa_pkg::*;

    // Front -> queue
    logic      q_push;
    t_cmd      q_cmd;
    logic      q_full;
    // Queue -> back
    t_cmd_head q_head;
    logic      q_pop;

    // Front end: decodes the opcode, range checks the slot and splits it
    // into word and bit, so the back end only sees ready-made commands.
    bsa_front u_front (
        .push           (push),
        .full           (full),
        .i_opcode       (i_opcode),
        .i_slot_to_free (i_slot_to_free),
        .i_q_full       (q_full),
        .o_q_push       (q_push),
        .o_q_cmd        (q_cmd)
    );

    // Two-entry command queue: requests keep flowing in while the back end
    // scans or while a finished result waits to be popped.
    bsa_cmd_queue u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_cmd),
        .o_full  (q_full),
        .o_head  (q_head),
        .i_pop   (q_pop)
    );

    // Back end: owns the bitmap and cursor, scans one word per cycle on an
    // allocate while its output register is empty or being popped, applies
    // frees, and holds one result transaction in its output register.
    bsa_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_head    (q_head),
        .o_cmd_pop (q_pop),
        .empty     (empty),
        .pop       (pop),
        .o_slot    (o_slot),
        .o_status  (o_status)
    );

endmodule

### hw/rtl/bsa_checker.sv
module bsa_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         full,
    input logic                         empty,
    input logic                         pop,
    input logic [bsa_pkg::SLOT_W-1:0]   o_slot,
    input logic [bsa_pkg::STATUS_W-1:0] o_status
);
    import bsa_pkg::*;

    // Reset leaves the result side empty and the request side not full
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("not empty after reset");

    // Only defined status codes leave the block
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_status == ST_OK || o_status == ST_NONE || o_status == ST_RANGE))
        else $error("undefined status");

    // Failed transactions carry slot zero
    a_fail_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_status != ST_OK) |-> o_slot == '0)
        else $error("nonzero slot on failure");

    // A waiting result holds until popped
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_slot) && $stable(o_status)))
        else $error("result changed while stalled");

endmodule

bind bitmap_slot_allocator bsa_checker u_bsa_checker (.*);
